// ===== src/sctb_pkg.sv =====
// shared types and constants of the scrolling text cell buffer
`timescale 1ns / 1ps
`default_nettype none

package sctb_pkg;

  // store geometry, fixed by the field widths
  localparam int MAX_COLS  = 32;
  localparam int TEXT_ROWS = 8;

  // character codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUERY   = 8'h3F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // command codes on the input channel
  typedef enum logic [1:0] {
    CMD_PUT_CHAR   = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_CLEAR      = 2'd2,
    CMD_DRAW       = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_COLUMNS     = 2'd0,
    REG_ROWS_IN_USE = 2'd1,
    REG_FIRST_PRINT = 2'd2,
    REG_LAST_PRINT  = 2'd3
  } reg_idx_t;

  // operations handed from front to back
  typedef enum logic [2:0] {
    OP_PUT_CHAR,
    OP_NEWLINE,
    OP_SET_CURSOR,
    OP_CLEAR,
    OP_DRAW
  } op_t;

  // effective configuration, already clamped to the legal range
  typedef struct packed {
    logic [5:0] cols;
    logic [3:0] rows;
    logic [7:0] first_print;
    logic [7:0] last_print;
  } cfg_t;

  // one queued operation
  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [5:0] col;
    logic [2:0] row;
  } entry_t;

  // one drawn cell
  typedef struct packed {
    logic [7:0] pixel_x;
    logic [2:0] screen_row;
    logic [7:0] glyph;
    logic       last;
  } cell_out_t;

  localparam int Q_DEPTH = 2;

endpackage

`default_nettype wire

// ===== src/scrolling_text_cell_buffer.sv =====
// top level of the scrolling text cell buffer
// put character: written from the idle state; newline or column wrap adds row reduction,
//   a blanking pass over the columns in use and, for a wrap, a write of the char
// draw row: after leaving the queue, row reduction, then cells one
//   per cycle through the registered read port, slowed only by out_tready
// clear and synchronous active-low reset: 256-cell sweep to spaces, in_tready low after reset
`timescale 1ns / 1ps
`default_nettype none

module scrolling_text_cell_buffer
  import sctb_pkg::*;
#(
  parameter int GLYPH_WIDTH = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_code, cursor_col, cursor_row
  input  wire logic [1:0]  in_tuser,   // command
  // drawn cells
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // pixel_x, screen_row, glyph
  output logic             out_tlast,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  // raw configuration registers
  logic [5:0] columns_r;
  logic [3:0] rows_r;
  logic [7:0] first_r;
  logic [7:0] last_r;

  cfg_t      cfg;
  logic      q_push;
  entry_t    q_entry;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  entry_t    q_head;
  logic      init_busy;
  cell_out_t out_cell;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= 6'd21;
      rows_r    <= 4'd8;
      first_r   <= 8'd32;
      last_r    <= 8'd126;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COLUMNS:     columns_r <= cfg_wdata[5:0];
        REG_ROWS_IN_USE: rows_r    <= cfg_wdata[3:0];
        REG_FIRST_PRINT: first_r   <= cfg_wdata;
        REG_LAST_PRINT:  last_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // clamp columns and rows to 1..MAX
  always_comb begin
    cfg.first_print = first_r;
    cfg.last_print  = last_r;
    if (columns_r == '0) begin
      cfg.cols = 6'd1;
    end else if ({1'b0, columns_r} > 7'(MAX_COLS)) begin
      cfg.cols = 6'(MAX_COLS);
    end else begin
      cfg.cols = columns_r;
    end
    if (rows_r == '0) begin
      cfg.rows = 4'd1;
    end else if ({1'b0, rows_r} > 5'(TEXT_ROWS)) begin
      cfg.rows = 4'(TEXT_ROWS);
    end else begin
      cfg.rows = rows_r;
    end
  end

  // front: decode and classify, drop draws of rows not in use
  sctb_front u_front (
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_command   (in_tuser),
    .in_char_code (in_tdata[7:0]),
    .in_cursor_col(in_tdata[13:8]),
    .in_cursor_row(in_tdata[16:14]),
    .cfg          (cfg),
    .q_full       (q_full),
    .init_busy    (init_busy),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  // decoupling queue
  sctb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .head      (q_head)
  );

  // back: cursor, store and row drawing
  sctb_back #(
    .GLYPH_WIDTH(GLYPH_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_not_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .init_busy(init_busy),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_cell (out_cell)
  );

  assign out_tdata = {5'd0, out_cell.glyph, out_cell.screen_row, out_cell.pixel_x};
  assign out_tlast = out_cell.last;

endmodule

`default_nettype wire

// ===== src/sctb_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/sctb_front.sv =====
// front end: accepts commands and turns them into queued operations
`timescale 1ns / 1ps
`default_nettype none

module sctb_front
  import sctb_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_char_code,
  input  wire logic [5:0] in_cursor_col,
  input  wire logic [2:0] in_cursor_row,
  input  wire cfg_t       cfg,
  input  wire logic       q_full,
  input  wire logic       init_busy,
  output logic            q_push,
  output entry_t          q_entry
);

  logic drop;
  logic row_over;

  assign row_over = {1'b0, in_cursor_row} >= cfg.rows;
  assign in_ready = !q_full && !init_busy;

  always_comb begin
    drop    = 1'b0;
    q_entry = '{op: OP_PUT_CHAR, ch: in_char_code, col: in_cursor_col, row: in_cursor_row};
    unique case (cmd_t'(in_command))
      CMD_PUT_CHAR: begin
        if (in_char_code == CH_NEWLINE) begin
          q_entry.op = OP_NEWLINE;
        end else if (in_char_code > cfg.last_print || in_char_code < cfg.first_print) begin
          q_entry.ch = CH_QUERY;
        end
      end
      CMD_SET_CURSOR: begin
        q_entry.op = OP_SET_CURSOR;
        if (row_over) begin
          q_entry.row = 3'(cfg.rows - 4'd1);
        end
      end
      CMD_CLEAR: begin
        q_entry.op = OP_CLEAR;
      end
      CMD_DRAW: begin
        q_entry.op = OP_DRAW;
        drop       = row_over;
      end
      default: begin
        drop = 1'b1;
      end
    endcase
  end

  assign q_push = in_valid && in_ready && !drop;

endmodule

`default_nettype wire

// ===== src/sctb_queue.sv =====
// short operation queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module sctb_queue
  import sctb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  output logic        not_empty,
  input  wire logic   pop,
  output entry_t      head
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  entry_t        slots_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = count_r == CW'(Q_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        slots_r[wr_ptr_r] <= push_entry;
        wr_ptr_r <= (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sctb_back.sv =====
// back end: cursor, cell store sequencing and row drawing
`timescale 1ns / 1ps
`default_nettype none

module sctb_back
  import sctb_pkg::*;
#(
  parameter int GLYPH_WIDTH = 6
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   q_valid,
  input  wire entry_t q_head,
  output logic        q_pop,
  output logic        init_busy,
  output logic        out_valid,
  input  wire logic   out_ready,
  output cell_out_t   out_cell
);

  localparam int CELLS = MAX_COLS * TEXT_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);
  localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MOD,
    ST_BLANK,
    ST_PUT_FIRST,
    ST_DRAW
  } state_t;

  state_t        state_r;
  logic          init_r;
  logic [AW-1:0] sweep_r;
  logic [5:0]    cur_col_r;
  logic [2:0]    cur_row_r;
  logic [3:0]    mod_r;
  logic          mod_draw_r;
  logic          has_ch_r;
  logic [7:0]    put_ch_r;
  logic [2:0]    draw_row_r;
  logic [2:0]    src_r;
  logic [5:0]    x_r;
  logic          pend_r;
  logic [5:0]    pend_x_r;
  logic          pend_last_r;
  logic [2:0]    pend_row_r;
  logic          out_valid_r;
  cell_out_t     out_cell_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          move;
  logic          go;
  logic          col_wrap;
  logic          x_last;

  function automatic logic [AW-1:0] cell_addr(input logic [2:0] row, input logic [5:0] col);
    cell_addr = AW'(AW'(row) * COLS_A + AW'(col));
  endfunction

  assign move     = pend_r && (!out_valid_r || out_ready);
  assign go       = !pend_r || move;
  assign col_wrap = cur_col_r >= cfg.cols;
  assign x_last   = x_r == cfg.cols - 6'd1;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr(cur_row_r, x_r);
    ram_wdata = CH_SPACE;
    unique case (state_r)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
      end
      ST_IDLE: begin
        if (q_valid && q_head.op == OP_PUT_CHAR && !col_wrap) begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr(cur_row_r, cur_col_r);
          ram_wdata = q_head.ch;
        end
      end
      ST_BLANK: begin
        ram_we = 1'b1;
      end
      ST_PUT_FIRST: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(cur_row_r, 6'd0);
        ram_wdata = put_ch_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_re    = (state_r == ST_DRAW) && go;
  assign ram_raddr = cell_addr(src_r, x_r);

  sctb_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      init_r      <= 1'b1;
      sweep_r     <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // read pipeline: ram output to output register
      if (move) begin
        out_valid_r           <= 1'b1;
        out_cell_r.pixel_x    <= 8'(32'(pend_x_r) * GLYPH_WIDTH);
        out_cell_r.screen_row <= pend_row_r;
        out_cell_r.glyph      <= ram_rdata;
        out_cell_r.last       <= pend_last_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ram_re) begin
        pend_r      <= 1'b1;
        pend_x_r    <= x_r;
        pend_last_r <= x_last;
        pend_row_r  <= draw_row_r;
      end else if (move) begin
        pend_r <= 1'b0;
      end

      unique case (state_r)
        ST_SWEEP: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == LAST_A) begin
            init_r  <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_head.op)
              OP_PUT_CHAR: begin
                if (col_wrap) begin
                  mod_r      <= {1'b0, cur_row_r} + 4'd1;
                  mod_draw_r <= 1'b0;
                  has_ch_r   <= 1'b1;
                  put_ch_r   <= q_head.ch;
                  state_r    <= ST_MOD;
                end else begin
                  cur_col_r <= cur_col_r + 6'd1;
                end
              end
              OP_NEWLINE: begin
                mod_r      <= {1'b0, cur_row_r} + 4'd1;
                mod_draw_r <= 1'b0;
                has_ch_r   <= 1'b0;
                state_r    <= ST_MOD;
              end
              OP_SET_CURSOR: begin
                cur_row_r <= q_head.row;
                cur_col_r <= q_head.col;
              end
              OP_CLEAR: begin
                sweep_r <= '0;
                state_r <= ST_SWEEP;
              end
              OP_DRAW: begin
                mod_r      <= {1'b0, cur_row_r} + {1'b0, q_head.row} + 4'd1;
                mod_draw_r <= 1'b1;
                draw_row_r <= q_head.row;
                state_r    <= ST_MOD;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MOD: begin
          // reduce modulo rows in use by repeated subtraction
          if (mod_r >= cfg.rows) begin
            mod_r <= mod_r - cfg.rows;
          end else if (mod_draw_r) begin
            src_r   <= mod_r[2:0];
            x_r     <= '0;
            state_r <= ST_DRAW;
          end else begin
            cur_row_r <= mod_r[2:0];
            cur_col_r <= '0;
            x_r       <= '0;
            state_r   <= ST_BLANK;
          end
        end
        ST_BLANK: begin
          x_r <= x_r + 6'd1;
          if (x_last) begin
            state_r <= has_ch_r ? ST_PUT_FIRST : ST_IDLE;
          end
        end
        ST_PUT_FIRST: begin
          cur_col_r <= 6'd1;
          state_r   <= ST_IDLE;
        end
        ST_DRAW: begin
          if (go) begin
            x_r <= x_r + 6'd1;
            if (x_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_cell  = out_cell_r;

endmodule

`default_nettype wire

// ===== src/sctb_checker.sv =====
// port-level checks of the scrolling text cell buffer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module sctb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);

  logic       first_r;
  logic [2:0] row_r;

  // track row boundaries on the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      first_r <= out_tlast;
      row_r   <= out_tdata[10:8];
    end
  end

  // the store sweep after reset holds off commands
  a_reset_holds_input: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("command accepted right after reset");

  // a row always starts at pixel zero
  a_row_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && first_r |-> out_tdata[7:0] == 8'd0)
    else $error("drawn row does not start at pixel zero");

  // all cells of one row carry the same screen row
  a_row_constant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !first_r |-> out_tdata[10:8] == row_r)
    else $error("screen row changed within a drawn row");

  // stalled cell holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output cell changed");

endmodule

bind scrolling_text_cell_buffer sctb_checker u_sctb_checker (.*);

`default_nettype wire
